[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the noise suppressor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/wns_pkg.sv]
// ----------------------------------------------------------------------------
// wns_pkg
// Types and constants shared by the noise suppressor modules.
// ----------------------------------------------------------------------------
package wns_pkg;

    // Configuration register indexes.
    typedef enum logic [3:0] {
        CFG_DD_ALPHA       = 4'd0,
        CFG_XI_MIN         = 4'd1,
        CFG_XI_MAX         = 4'd2,
        CFG_MIN_GAIN       = 4'd3,
        CFG_MAX_GAIN       = 4'd4,
        CFG_GAIN_SMOOTHING = 4'd5,
        CFG_FREQ_SMOOTHING = 4'd6,
        CFG_NOISE_ALPHA    = 4'd7
    } t_cfg_idx;

    // Register reset values.
    localparam logic [15:0] RST_DD_ALPHA       = 16'd64225;
    localparam logic [15:0] RST_XI_MIN         = 16'd8;
    localparam logic [15:0] RST_XI_MAX         = 16'd65535;
    localparam logic [15:0] RST_MIN_GAIN       = 16'd3277;
    localparam logic [15:0] RST_MAX_GAIN       = 16'd32768;
    localparam logic [15:0] RST_GAIN_SMOOTHING = 16'd45875;
    localparam logic [15:0] RST_FREQ_SMOOTHING = 16'd0;
    localparam logic [15:0] RST_NOISE_ALPHA    = 16'd62259;

    // Fixed-point constants.
    localparam logic [15:0] UNITY_GAIN = 16'd32768;
    localparam logic [15:0] Q88_ONE    = 16'd256;

    // Configuration register file contents.
    typedef struct packed {
        logic [15:0] dd_alpha;
        logic [15:0] xi_min;
        logic [15:0] xi_max;
        logic [15:0] min_gain;
        logic [15:0] max_gain;
        logic [15:0] gain_smoothing;
        logic [15:0] freq_smoothing;
        logic [15:0] noise_alpha;
    } t_cfg;

    // Position of a bin within its frame.
    typedef struct packed {
        logic first;
        logic second;
        logic last;
    } t_tag;

    // Control from the back end to the front end.
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctl;

endpackage

[design/wns_front.sv]
// ----------------------------------------------------------------------------
// wns_front
// Accepts spectral bins, tags each with its bin index and frame position,
// and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module wns_front
    import wns_pkg::*;
#(
    parameter int NUM_BINS = 257,
    parameter int AW       = $clog2(NUM_BINS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [15:0]   i_bin_real,
    input  logic signed [15:0]   i_bin_imag,
    input  t_back_ctl            i_ctl,
    output logic                 o_head_valid,
    output logic [15:0]          o_head_re,
    output logic [15:0]          o_head_im,
    output logic [AW-1:0]        o_head_k,
    output t_tag                 o_head_tag
);

    logic [AW-1:0] r_bin;
    logic [1:0]    r_cnt;
    logic          r_wp;
    logic          r_rp;
    logic [15:0]   r_q_re  [2];
    logic [15:0]   r_q_im  [2];
    logic [AW-1:0] r_q_k   [2];
    t_tag          r_q_tag [2];
    logic          push;
    logic          pop;
    t_tag          tag;

    // The queue refuses requests when full or while memories are cleared.
    assign o_in_stall = (r_cnt == 2'd2) || i_ctl.clearing;
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_ctl.pop && (r_cnt != 2'd0);

    // Classify the bin by its place in the frame.
    always_comb begin
        tag.first  = (r_bin == '0);
        tag.second = (r_bin == AW'(1));
        tag.last   = (r_bin == AW'(NUM_BINS - 1));
    end

    // Bin counter and queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin <= '0;
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (push) begin
                r_bin <= tag.last ? '0 : r_bin + AW'(1);
                r_wp  <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_re[r_wp]  <= i_bin_real;
            r_q_im[r_wp]  <= i_bin_imag;
            r_q_k[r_wp]   <= r_bin;
            r_q_tag[r_wp] <= tag;
        end
    end

    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head_re    = r_q_re[r_rp];
    assign o_head_im    = r_q_im[r_rp];
    assign o_head_k     = r_q_k[r_rp];
    assign o_head_tag   = r_q_tag[r_rp];

endmodule

[design/wns_div.sv]
// ----------------------------------------------------------------------------
// wns_div
// Restoring divider, one quotient bit per cycle, for quotients below 2^16.
// The caller guarantees that the dividend shifted right by 16 is below the
// divisor.
// ----------------------------------------------------------------------------
module wns_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [39:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic        o_done,
    output logic [15:0] o_quo
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [15:0] r_lo;
    logic [31:0] r_den;
    logic [15:0] r_q;
    logic [32:0] trial;
    logic        qbit;
    logic [31:0] n_rem;

    // One restoring step.
    always_comb begin
        trial = {r_rem, r_lo[15]};
        qbit  = (trial >= {1'b0, r_den});
        n_rem = qbit ? 32'(trial - {1'b0, r_den}) : trial[31:0];
    end

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd16;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {8'd0, i_num[39:16]};
            r_lo  <= i_num[15:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_lo  <= {r_lo[14:0], 1'b0};
            r_q   <= {r_q[14:0], qbit};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

[design/wns_back.sv]
// ----------------------------------------------------------------------------
// wns_back
// Per-bin sequencer: noise tracking, SNR estimation, Wiener gain, smoothing
// in time and frequency, and scaling of the delayed bin. Owns the per-bin
// memories and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wns_back
    import wns_pkg::*;
#(
    parameter int NUM_BINS = 257,
    parameter int AW       = $clog2(NUM_BINS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_head_valid,
    input  logic [15:0]   i_head_re,
    input  logic [15:0]   i_head_im,
    input  logic [AW-1:0] i_head_k,
    input  t_tag          i_head_tag,
    output t_back_ctl     o_ctl,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [15:0]   o_out_real,
    output logic [15:0]   o_out_imag,
    output logic [15:0]   o_out_gain,
    output logic          o_last_of_frame
);

    typedef enum logic [25:0] {
        S_IDLE      = 26'h0000001,
        S_SQR_RE    = 26'h0000002,
        S_SQR_IM    = 26'h0000004,
        S_NZ_A      = 26'h0000008,
        S_NZ_B      = 26'h0000010,
        S_NZ_C      = 26'h0000020,
        S_GAM_START = 26'h0000040,
        S_GAM_WAIT  = 26'h0000080,
        S_X1        = 26'h0000100,
        S_X2        = 26'h0000200,
        S_X3        = 26'h0000400,
        S_X4        = 26'h0000800,
        S_X5        = 26'h0001000,
        S_G_START   = 26'h0002000,
        S_G_WAIT    = 26'h0004000,
        S_T1        = 26'h0008000,
        S_T2        = 26'h0010000,
        S_T3        = 26'h0020000,
        S_B1        = 26'h0040000,
        S_B2        = 26'h0080000,
        S_B3        = 26'h0100000,
        S_WB        = 26'h0200000,
        S_SC_RE     = 26'h0400000,
        S_SC_IM     = 26'h0800000,
        S_PUSH      = 26'h1000000,
        S_SHIFT     = 26'h2000000
    } t_state;

    t_state r_st;

    // Per-bin memories and their read registers.
    logic [31:0] mem_noise [NUM_BINS];
    logic [15:0] mem_gain  [NUM_BINS];
    logic [15:0] mem_psnr  [NUM_BINS];
    logic [31:0] r_rd_noise;
    logic [15:0] r_rd_gain;
    logic [15:0] r_rd_psnr;

    // Clearing pass.
    logic          r_clr;
    logic [AW-1:0] r_clr_idx;

    // Item and working registers.
    logic [15:0]        r_re;
    logic [15:0]        r_im;
    logic [AW-1:0]      r_k;
    t_tag               r_tag;
    logic [31:0]        r_y2;
    logic [31:0]        r_lam;
    logic [15:0]        r_gp;
    logic [15:0]        r_psnr;
    logic [63:0]        r_acc;
    logic [64:0]        r_prod;
    logic [15:0]        r_gamma;
    logic [15:0]        r_xi;
    logic [15:0]        r_g;
    logic [15:0]        r_gt;
    logic [15:0]        r_fg;
    logic [31:0]        r_hb1;
    logic [15:0]        r_hg0;
    logic [15:0]        r_hg1;
    logic [31:0]        r_sc_bin;
    logic [15:0]        r_sc_gain;
    logic               r_sc_last;
    logic [15:0]        r_ore;
    logic signed [33:0] r_sprod;

    // Output register.
    logic        r_o_valid;
    logic [15:0] r_o_re;
    logic [15:0] r_o_im;
    logic [15:0] r_o_gain;
    logic        r_o_last;

    // Combinational helpers.
    logic               pop;
    logic               out_free;
    logic [AW-1:0]      rd_addr;
    logic [47:0]        mul_a;
    logic [16:0]        mul_b;
    logic [64:0]        mul_p;
    logic signed [16:0] re_x;
    logic signed [16:0] im_x;
    logic [16:0]        re_abs;
    logic [16:0]        im_abs;
    logic [63:0]        nz_sum;
    logic [31:0]        new_lam;
    logic               nz_upd;
    logic [31:0]        gam_den;
    logic               gam_sat;
    logic [15:0]        ml;
    logic [64:0]        xi_tot;
    logic [15:0]        xi_sat;
    logic [15:0]        xi_lo;
    logic [15:0]        xi_clamp;
    logic [15:0]        g_lo;
    logic [15:0]        g_hi;
    logic [15:0]        g_clamp;
    logic [63:0]        gt_sum;
    logic [17:0]        nb_sum;
    logic [63:0]        fg_sum;
    logic signed [15:0] sc_in;
    logic signed [33:0] sc_p;
    logic signed [18:0] sc_round;
    logic [15:0]        sc_sat;
    logic               div_start;
    logic [39:0]        div_num;
    logic [31:0]        div_den;
    logic               div_busy;
    logic               div_done;
    logic [15:0]        div_quo;
    logic               we_noise;
    logic               we_gain;
    logic               we_psnr;
    logic [AW-1:0]      wa_noise;
    logic [AW-1:0]      wa_gain;
    logic [AW-1:0]      wa_psnr;
    logic [31:0]        wd_noise;
    logic [15:0]        wd_gain;
    logic [15:0]        wd_psnr;

    assign pop          = (r_st == S_IDLE) && !r_clr && i_head_valid;
    assign o_ctl.pop    = pop;
    assign o_ctl.clearing = r_clr;
    assign out_free     = !r_o_valid || !i_out_stall;
    assign rd_addr      = (r_st == S_IDLE) ? i_head_k : r_k;

    // Magnitudes of the input bin.
    always_comb begin
        re_x   = {r_re[15], r_re};
        im_x   = {r_im[15], r_im};
        re_abs = re_x[16] ? 17'(-re_x) : 17'(re_x);
        im_abs = im_x[16] ? 17'(-im_x) : 17'(im_x);
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_st)
            S_SQR_RE: begin
                mul_a = 48'(re_abs);
                mul_b = re_abs;
            end
            S_SQR_IM: begin
                mul_a = 48'(im_abs);
                mul_b = im_abs;
            end
            S_NZ_A: begin
                mul_a = 48'(r_lam);
                mul_b = {1'b0, i_cfg.noise_alpha};
            end
            S_NZ_B: begin
                mul_a = 48'(r_y2);
                mul_b = 17'h10000 - {1'b0, i_cfg.noise_alpha};
            end
            S_X1: begin
                mul_a = 48'(r_gp);
                mul_b = {1'b0, r_gp};
            end
            S_X2: begin
                mul_a = r_prod[47:0];
                mul_b = {1'b0, r_psnr};
            end
            S_X3: begin
                mul_a = r_prod[47:0];
                mul_b = {1'b0, i_cfg.dd_alpha};
            end
            S_X4: begin
                mul_a = 48'(ml);
                mul_b = 17'h10000 - {1'b0, i_cfg.dd_alpha};
            end
            S_T1: begin
                mul_a = 48'(r_gp);
                mul_b = {1'b0, i_cfg.gain_smoothing};
            end
            S_T2: begin
                mul_a = 48'(r_g);
                mul_b = 17'h10000 - {1'b0, i_cfg.gain_smoothing};
            end
            S_B1: begin
                mul_a = 48'(nb_sum);
                mul_b = {1'b0, i_cfg.freq_smoothing};
            end
            S_B2: begin
                mul_a = 48'(r_hg1);
                mul_b = 17'h10000 - {1'b0, i_cfg.freq_smoothing};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = {17'd0, mul_a} * {48'd0, mul_b};
    end

    // Noise update: recursive average, gated on low energy or empty estimate.
    always_comb begin
        nz_sum  = r_acc + r_prod[63:0] + 64'd32768;
        new_lam = nz_sum[47:16];
        nz_upd  = (r_lam == '0) || ({1'b0, r_y2} < {r_lam, 1'b0});
    end

    // A posteriori SNR: saturate when the quotient would reach 2^16.
    always_comb begin
        gam_den = (r_lam == '0) ? 32'd1 : r_lam;
        gam_sat = ({8'd0, r_y2[31:8]} >= gam_den);
        ml      = (r_gamma > Q88_ONE) ? (r_gamma - Q88_ONE) : 16'd0;
    end

    // Decision-directed a priori SNR with saturation and clamps.
    always_comb begin
        xi_tot   = {1'b0, r_acc} + ({32'd0, r_prod[32:0]} << 30) + (65'd1 << 45);
        xi_sat   = (xi_tot[64:62] != 3'd0) ? 16'hFFFF : xi_tot[61:46];
        xi_lo    = (xi_sat < i_cfg.xi_min) ? i_cfg.xi_min : xi_sat;
        xi_clamp = (xi_lo > i_cfg.xi_max) ? i_cfg.xi_max : xi_lo;
    end

    // Wiener gain clamps; max_gain wins over min_gain, unity caps both.
    always_comb begin
        g_lo    = (div_quo < i_cfg.min_gain) ? i_cfg.min_gain : div_quo;
        g_hi    = (g_lo > i_cfg.max_gain) ? i_cfg.max_gain : g_lo;
        g_clamp = (g_hi > UNITY_GAIN) ? UNITY_GAIN : g_hi;
    end

    // Temporal and frequency smoothing sums.
    always_comb begin
        gt_sum = r_acc + r_prod[63:0] + 64'd32768;
        nb_sum = {2'd0, r_hg0} + {1'b0, r_hg1, 1'b0} + {2'd0, r_gt};
        fg_sum = r_acc + {r_prod[61:0], 2'b00} + 64'd131072;
    end

    // Divider operands for the SNR and the gain.
    always_comb begin
        div_start = 1'b0;
        div_num   = {r_y2, 8'd0};
        div_den   = gam_den;
        if (r_st == S_GAM_START) begin
            div_start = !gam_sat;
        end else if (r_st == S_G_START) begin
            div_start = 1'b1;
            div_num   = {9'd0, r_xi, 15'd0};
            div_den   = {15'd0, {1'b0, r_xi} + 17'd256};
        end
    end

    wns_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Scaling of a bin half by the gain, rounded half up and saturated.
    always_comb begin
        sc_in    = (r_st == S_SC_RE) ? signed'(r_sc_bin[15:0]) : signed'(r_sc_bin[31:16]);
        sc_p     = sc_in * signed'({2'b00, r_sc_gain});
        sc_round = 19'((r_sprod + 34'sd16384) >>> 15);
        if (sc_round > 19'sd32767) begin
            sc_sat = 16'h7FFF;
        end else if (sc_round < -19'sd32768) begin
            sc_sat = 16'h8000;
        end else begin
            sc_sat = sc_round[15:0];
        end
    end

    // Memory write ports.
    always_comb begin
        we_noise = r_clr || ((r_st == S_NZ_C) && nz_upd);
        wa_noise = r_clr ? r_clr_idx : r_k;
        wd_noise = r_clr ? 32'd0 : new_lam;
        we_gain  = r_clr || ((r_st == S_T3) && r_tag.last) || (r_st == S_WB);
        wa_gain  = r_clr ? r_clr_idx : ((r_st == S_WB) ? r_k - AW'(1) : r_k);
        wd_gain  = r_clr ? UNITY_GAIN : ((r_st == S_WB) ? r_fg : gt_sum[31:16]);
        we_psnr  = r_clr || (r_st == S_T3);
        wa_psnr  = r_clr ? r_clr_idx : r_k;
        wd_psnr  = r_clr ? Q88_ONE : r_gamma;
    end

    // Per-bin memories.
    always_ff @(posedge i_clk) begin
        if (we_noise) begin
            mem_noise[wa_noise] <= wd_noise;
        end
        if (we_gain) begin
            mem_gain[wa_gain] <= wd_gain;
        end
        if (we_psnr) begin
            mem_psnr[wa_psnr] <= wd_psnr;
        end
        r_rd_noise <= mem_noise[rd_addr];
        r_rd_gain  <= mem_gain[rd_addr];
        r_rd_psnr  <= mem_psnr[rd_addr];
    end

    // Clearing pass after reset and the sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_idx <= '0;
            r_st      <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_idx <= r_clr_idx + AW'(1);
                if (r_clr_idx == AW'(NUM_BINS - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            // The output register empties when taken, unless it is reloaded.
            if (r_o_valid && !i_out_stall && !((r_st == S_PUSH) && out_free)) begin
                r_o_valid <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (pop) begin
                        r_st <= S_SQR_RE;
                    end
                end
                S_SQR_RE:    r_st <= S_SQR_IM;
                S_SQR_IM:    r_st <= S_NZ_A;
                S_NZ_A:      r_st <= S_NZ_B;
                S_NZ_B:      r_st <= S_NZ_C;
                S_NZ_C:      r_st <= S_GAM_START;
                S_GAM_START: r_st <= gam_sat ? S_X1 : S_GAM_WAIT;
                S_GAM_WAIT: begin
                    if (div_done) begin
                        r_st <= S_X1;
                    end
                end
                S_X1:        r_st <= S_X2;
                S_X2:        r_st <= S_X3;
                S_X3:        r_st <= S_X4;
                S_X4:        r_st <= S_X5;
                S_X5:        r_st <= S_G_START;
                S_G_START:   r_st <= S_G_WAIT;
                S_G_WAIT: begin
                    if (div_done) begin
                        r_st <= S_T1;
                    end
                end
                S_T1:        r_st <= S_T2;
                S_T2:        r_st <= S_T3;
                S_T3: begin
                    if (r_tag.first) begin
                        r_st <= S_SHIFT;
                    end else if (r_tag.second) begin
                        r_st <= S_WB;
                    end else begin
                        r_st <= S_B1;
                    end
                end
                S_B1:        r_st <= S_B2;
                S_B2:        r_st <= S_B3;
                S_B3:        r_st <= S_WB;
                S_WB:        r_st <= S_SC_RE;
                S_SC_RE:     r_st <= S_SC_IM;
                S_SC_IM:     r_st <= S_PUSH;
                S_PUSH: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        if (!r_sc_last && r_tag.last) begin
                            r_st <= S_SC_RE;
                        end else begin
                            r_st <= S_SHIFT;
                        end
                    end
                end
                S_SHIFT:     r_st <= S_IDLE;
                default:     r_st <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_st)
            S_IDLE: begin
                r_re  <= i_head_re;
                r_im  <= i_head_im;
                r_k   <= i_head_k;
                r_tag <= i_head_tag;
            end
            S_SQR_RE: begin
                r_lam  <= r_rd_noise;
                r_gp   <= r_rd_gain;
                r_psnr <= r_rd_psnr;
            end
            S_SQR_IM: r_y2  <= r_prod[31:0];
            S_NZ_A:   r_y2  <= r_y2 + r_prod[31:0];
            S_NZ_B:   r_acc <= r_prod[63:0];
            S_NZ_C: begin
                if (nz_upd) begin
                    r_lam <= new_lam;
                end
            end
            S_GAM_START: begin
                if (gam_sat) begin
                    r_gamma <= 16'hFFFF;
                end
            end
            S_GAM_WAIT: begin
                if (div_done) begin
                    r_gamma <= div_quo;
                end
            end
            S_X4:     r_acc <= r_prod[63:0];
            S_X5:     r_xi  <= xi_clamp;
            S_G_WAIT: begin
                if (div_done) begin
                    r_g <= g_clamp;
                end
            end
            S_T2:     r_acc <= r_prod[63:0];
            S_T3: begin
                r_gt <= gt_sum[31:16];
                r_fg <= r_hg1;
            end
            S_B2:     r_acc <= r_prod[63:0];
            S_B3:     r_fg  <= fg_sum[33:18];
            S_WB: begin
                r_sc_bin  <= r_hb1;
                r_sc_gain <= r_fg;
                r_sc_last <= 1'b0;
            end
            S_SC_RE:  r_sprod <= sc_p;
            S_SC_IM: begin
                r_ore   <= sc_sat;
                r_sprod <= sc_p;
            end
            S_PUSH: begin
                if (out_free) begin
                    r_o_re    <= r_ore;
                    r_o_im    <= sc_sat;
                    r_o_gain  <= r_sc_gain;
                    r_o_last  <= r_sc_last;
                    r_sc_bin  <= {r_im, r_re};
                    r_sc_gain <= r_gt;
                    r_sc_last <= 1'b1;
                end
            end
            S_SHIFT: begin
                r_hg0 <= r_hg1;
                r_hg1 <= r_gt;
                r_hb1 <= {r_im, r_re};
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_out_valid     = r_o_valid;
    assign o_out_real      = r_o_re;
    assign o_out_imag      = r_o_im;
    assign o_out_gain      = r_o_gain;
    assign o_last_of_frame = r_o_last;

    // No item is taken while the memories are being cleared.
    `ASSERT_SAME(a_no_pop_clr, i_clk, i_rst_n, r_clr, !o_ctl.pop)
    // The divider is only started when it is free.
    `ASSERT_SAME(a_div_free, i_clk, i_rst_n, div_start, !div_busy)
    // A delivered gain never exceeds unity.
    `ASSERT_SAME(a_gain_unity, i_clk, i_rst_n, r_o_valid, r_o_gain <= UNITY_GAIN)
    // A loaded result shows up as valid in the next cycle.
    `ASSERT_NEXT(a_push_valid, i_clk, i_rst_n, (r_st == S_PUSH) && out_free, r_o_valid)

endmodule

[design/wiener_noise_suppressor.sv]
// ----------------------------------------------------------------------------
// wiener_noise_suppressor
// Decision-directed Wiener noise suppressor over complex spectral bins.
// ----------------------------------------------------------------------------
// Each bin holds the back end through two 16-step divisions (a posteriori
// SNR and Wiener gain) and its multiply steps on one multiplier; the first
// division is skipped when the SNR saturates, no result leaves with a frame's
// first bin, its last bin is scaled and sent as well, and output stalls hold
// the back end. A result leaves one bin late, after its successor is taken;
// a two-entry queue holds waiting bins. After reset the per-bin memories are
// cleared with input stalled; configuration writes are taken at any time.
module wiener_noise_suppressor
    import wns_pkg::*;
#(
    parameter int NUM_BINS = 257
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_bin_real,
    input  logic [15:0] i_bin_imag,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_out_real,
    output logic [15:0] o_out_imag,
    output logic [15:0] o_out_gain,
    output logic        o_last_of_frame,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int AW = $clog2(NUM_BINS);

    t_cfg          r_cfg;
    t_back_ctl     ctl;
    logic          head_valid;
    logic [15:0]   head_re;
    logic [15:0]   head_im;
    logic [AW-1:0] head_k;
    t_tag          head_tag;

    assign o_cfg_ready = 1'b1;

    // Configuration register file; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dd_alpha       <= RST_DD_ALPHA;
            r_cfg.xi_min         <= RST_XI_MIN;
            r_cfg.xi_max         <= RST_XI_MAX;
            r_cfg.min_gain       <= RST_MIN_GAIN;
            r_cfg.max_gain       <= RST_MAX_GAIN;
            r_cfg.gain_smoothing <= RST_GAIN_SMOOTHING;
            r_cfg.freq_smoothing <= RST_FREQ_SMOOTHING;
            r_cfg.noise_alpha    <= RST_NOISE_ALPHA;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DD_ALPHA:       r_cfg.dd_alpha       <= i_cfg_data;
                CFG_XI_MIN:         r_cfg.xi_min         <= i_cfg_data;
                CFG_XI_MAX:         r_cfg.xi_max         <= i_cfg_data;
                CFG_MIN_GAIN:       r_cfg.min_gain       <= i_cfg_data;
                CFG_MAX_GAIN:       r_cfg.max_gain       <= i_cfg_data;
                CFG_GAIN_SMOOTHING: r_cfg.gain_smoothing <= i_cfg_data;
                CFG_FREQ_SMOOTHING: r_cfg.freq_smoothing <= i_cfg_data;
                CFG_NOISE_ALPHA:    r_cfg.noise_alpha    <= i_cfg_data;
                default:            r_cfg <= r_cfg;
            endcase
        end
    end

    wns_front #(
        .NUM_BINS (NUM_BINS),
        .AW       (AW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_bin_real   (i_bin_real),
        .i_bin_imag   (i_bin_imag),
        .i_ctl        (ctl),
        .o_head_valid (head_valid),
        .o_head_re    (head_re),
        .o_head_im    (head_im),
        .o_head_k     (head_k),
        .o_head_tag   (head_tag)
    );

    wns_back #(
        .NUM_BINS (NUM_BINS),
        .AW       (AW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_head_valid    (head_valid),
        .i_head_re       (head_re),
        .i_head_im       (head_im),
        .i_head_k        (head_k),
        .i_head_tag      (head_tag),
        .o_ctl           (ctl),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_real      (o_out_real),
        .o_out_imag      (o_out_imag),
        .o_out_gain      (o_out_gain),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule
